@@ hdl/sns_pkg.sv @@
`timescale 1ns / 1ps

package sns_pkg;

  localparam int SPRITE_SIZE    = 64;
  localparam int FRAME_COUNT    = 4;
  localparam int SCREEN_COLUMNS = 320;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 24;
  localparam logic [31:0] ACC_MAX      = 32'h00FF_FFFF;
  localparam logic [31:0] SCREEN_LIMIT = 32'd64000;

  // Field widths fixed by the interface
  localparam int SIZE_W   = 8;
  localparam int DX_W     = 9;
  localparam int DY_W     = 8;
  localparam int FRAME_W  = 2;
  localparam int LIDX_W   = 12;
  localparam int TEXEL_W  = 8;
  localparam int SADDR_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int IDX_W        = $clog2(SPRITE_SIZE);
  localparam int FRAME_TEXELS = SPRITE_SIZE * SPRITE_SIZE;
  localparam int STORE_DEPTH  = FRAME_COUNT * FRAME_TEXELS;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);

  // Step division: (SPRITE_SIZE << FRAC_BITS) / dest_size
  localparam logic [31:0] DIVIDEND = 32'(SPRITE_SIZE) << FRAC_BITS;
  localparam int DIV_W = $clog2(SPRITE_SIZE * (1 << FRAC_BITS) + 1);
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Full screen address before masking
  localparam int SCR_FULL_W = $clog2(510 * SCREEN_COLUMNS + 767 + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_SIZE    = 2'd0,
    REG_DEST_X       = 2'd1,
    REG_DEST_Y       = 2'd2,
    REG_FRAME_SELECT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [FRAME_W-1:0] load_frame;
    logic [LIDX_W-1:0] load_index;
    logic [TEXEL_W-1:0] load_value;
  } sns_in_t;

  typedef struct packed {
    logic [SADDR_W-1:0] screen_address;
    logic [TEXEL_W-1:0] pixel;
    logic               write_enable;
    logic               last;
  } sns_out_t;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/sprite_nearest_scaler_core.sv @@
`timescale 1ns / 1ps

// Nearest-neighbour sprite scaler with transparency.
// Input words arrive on in_valid / in_stall / in_data. A load word (mode 0)
// writes one texel into the sprite store without raising in_stall. A step
// word (mode 1) produces one destination pixel on out_valid / out_stall /
// out_data, row by row, left to right; last marks the final pixel of the
// square, after which the next step word begins a fresh run.
// A step word raises in_stall while it passes through store read and result
// forming and back to idle; it takes no new word until then. The first step
// word of a run also waits for the iterative step divider, one quotient bit
// per cycle. Registers are written on cfg_write with cfg_index and
// cfg_data; writing dest_size ends the current run. dest_x, dest_y and
// frame_select are used live for each pixel.
// A stalled result holds in the output register; the block accepts the
// next word meanwhile but will not form a new result until it drains.
// Reset restores the register defaults and ends any run; the sprite store
// is not cleared and must be loaded before it is read.

module sprite_nearest_scaler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sns_pkg::sns_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sns_pkg::sns_out_t              out_data,
  input  logic                           cfg_write,
  input  logic [sns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sns_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sns_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_READ,
    S_FORM
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]  dest_size;
  logic [DX_W-1:0]    dest_x;
  logic [DY_W-1:0]    dest_y;
  logic [FRAME_W-1:0] frame_select;

  logic              run_active;
  logic [SIZE_W-1:0] out_row;
  logic [SIZE_W-1:0] out_col;
  logic [ACC_W-1:0]  src_x_accum;
  logic [ACC_W-1:0]  src_y_accum;
  logic [ACC_W-1:0]  step_value;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               accept;
  logic               load_hit;
  logic [STORE_AW-1:0] load_addr;
  logic [STORE_AW-1:0] read_addr;
  logic [TEXEL_W-1:0]  read_data;

  logic [IDX_W-1:0]   src_row;
  logic [IDX_W-1:0]   src_col;
  logic               frame_ok;
  logic [TEXEL_W-1:0] texel;
  logic [DY_W:0]      row_sum;
  logic [SCR_FULL_W-1:0] full_addr;
  logic               last_col;
  logic               last_row;
  logic               out_free;
  logic [ACC_W:0]     x_sum;
  logic [ACC_W:0]     y_sum;
  logic [ACC_W-1:0]   x_accum_next;
  logic [ACC_W-1:0]   y_accum_next;
  logic [ACC_W-1:0]   step_value_next;

  function automatic logic [IDX_W-1:0] src_index(input logic [ACC_W-1:0] acc);
    logic [ACC_W-FRAC_BITS-1:0] ipart;
    ipart = acc[ACC_W-1:FRAC_BITS];
    if (32'(ipart) >= SPRITE_SIZE) begin
      return IDX_W'(SPRITE_SIZE - 1);
    end
    return IDX_W'(ipart);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Texel loads go straight into the store
  assign load_hit  = accept && (in_data.mode == MODE_LOAD) &&
                     (32'(in_data.load_frame) < FRAME_COUNT) &&
                     (32'(in_data.load_index) < FRAME_TEXELS);
  assign load_addr = STORE_AW'(32'(in_data.load_frame) * FRAME_TEXELS +
                               32'(in_data.load_index));

  always_comb begin
    src_row   = src_index(src_y_accum);
    src_col   = src_index(src_x_accum);
    read_addr = STORE_AW'(32'(frame_select) * FRAME_TEXELS +
                          32'(src_row) * SPRITE_SIZE + 32'(src_col));
  end

  sns_texel_store u_store (
    .clk     (clk),
    .wr_en   (load_hit),
    .wr_addr (load_addr),
    .wr_data (in_data.load_value),
    .rd_addr (read_addr),
    .rd_data (read_data)
  );

  assign div_req.start   = accept && (in_data.mode == MODE_STEP) &&
                           (dest_size != '0) && !run_active;
  assign div_req.divisor = dest_size;

  sns_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    frame_ok  = 32'(frame_select) < FRAME_COUNT;
    texel     = frame_ok ? read_data : '0;
    row_sum   = {1'b0, dest_y} + {1'b0, out_row};
    full_addr = SCR_FULL_W'(32'(row_sum) * SCREEN_COLUMNS + 32'(dest_x) + 32'(out_col));
    last_col  = ({1'b0, out_col} + 1'b1) >= {1'b0, dest_size};
    last_row  = ({1'b0, out_row} + 1'b1) >= {1'b0, dest_size};
    x_sum     = {1'b0, src_x_accum} + {1'b0, step_value};
    y_sum     = {1'b0, src_y_accum} + {1'b0, step_value};
    // saturate on carry
    x_accum_next = x_sum[ACC_W] ? '1 : x_sum[ACC_W-1:0];
    y_accum_next = y_sum[ACC_W] ? '1 : y_sum[ACC_W-1:0];
    step_value_next = (32'(div_rsp.quotient) > ACC_MAX) ? ACC_MAX[ACC_W-1:0]
                                                        : ACC_W'(div_rsp.quotient);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      run_active   <= 1'b0;
      out_valid    <= 1'b0;
      dest_size    <= SIZE_W'(64);
      dest_x       <= DX_W'(128);
      dest_y       <= DY_W'(68);
      frame_select <= '0;
      out_row      <= '0;
      out_col      <= '0;
      src_x_accum  <= '0;
      src_y_accum  <= '0;
      step_value   <= '0;
    end else begin
      // drop a taken word unless a new one replaces it this cycle
      if (out_valid && !out_stall && (state != S_FORM)) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_DEST_SIZE: begin
            dest_size  <= cfg_data[SIZE_W-1:0];
            run_active <= 1'b0;
          end
          REG_DEST_X:       dest_x       <= cfg_data[DX_W-1:0];
          REG_DEST_Y:       dest_y       <= cfg_data[DY_W-1:0];
          REG_FRAME_SELECT: frame_select <= cfg_data[FRAME_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept && (in_data.mode == MODE_STEP) && (dest_size != '0)) begin
            state <= run_active ? S_READ : S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_rsp.done) begin
            step_value  <= step_value_next;
            out_row     <= '0;
            out_col     <= '0;
            src_x_accum <= '0;
            src_y_accum <= '0;
            run_active  <= 1'b1;
            state       <= S_READ;
          end
        end
        S_READ: begin
          state <= S_FORM;
        end
        S_FORM: begin
          // hold until the output register can take the word
          if (out_free) begin
            out_valid               <= 1'b1;
            out_data.screen_address <= full_addr[SADDR_W-1:0];
            out_data.pixel          <= texel;
            out_data.write_enable   <= (texel != '0) && (32'(full_addr) < SCREEN_LIMIT);
            out_data.last           <= last_col && last_row;
            if (last_col && last_row) begin
              run_active  <= 1'b0;
              out_row     <= '0;
              out_col     <= '0;
              src_x_accum <= '0;
              src_y_accum <= '0;
            end else if (last_col) begin
              out_col     <= '0;
              src_x_accum <= '0;
              out_row     <= out_row + 1'b1;
              src_y_accum <= y_accum_next;
            end else begin
              out_col     <= out_col + 1'b1;
              src_x_accum <= x_accum_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/sns_divider.sv @@
`timescale 1ns / 1ps

module sns_divider (
  input  logic              clk,
  input  logic              rst,
  input  sns_pkg::div_req_t req,
  output sns_pkg::div_rsp_t rsp
);
  import sns_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SIZE_W-1:0]    divisor;
  logic [SIZE_W-1:0]    rem;
  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     quo;

  logic [SIZE_W:0] trial;
  logic [SIZE_W:0] diff;
  logic            qbit;

  // One restoring step per cycle: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        divisor <= req.divisor;
        rem     <= '0;
        dvd     <= DIV_W'(DIVIDEND);
        quo     <= '0;
      end else if (busy) begin
        rem <= qbit ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        dvd <= {dvd[DIV_W-2:0], 1'b0};
        quo <= {quo[DIV_W-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ hdl/sns_texel_store.sv @@
`timescale 1ns / 1ps

module sns_texel_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [sns_pkg::STORE_AW-1:0] wr_addr,
  input  logic [sns_pkg::TEXEL_W-1:0]  wr_data,
  input  logic [sns_pkg::STORE_AW-1:0] rd_addr,
  output logic [sns_pkg::TEXEL_W-1:0]  rd_data
);
  import sns_pkg::*;

  logic [TEXEL_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/sns_checker.sv @@
`timescale 1ns / 1ps

module sns_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input sns_pkg::sns_out_t              out_data
);
  import sns_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // A new result only appears while an item is being worked on
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without an item in progress");

  // Transparent texels are never written
  a_transparent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_enable |-> out_data.pixel != '0)
    else $error("write enable on a transparent texel");

  // Writes stay inside the visible screen
  a_screen_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.write_enable |-> 32'(out_data.screen_address) < SCREEN_LIMIT)
    else $error("write enable beyond the screen");

endmodule

bind sprite_nearest_scaler_core sns_checker u_sns_checker (.*);
